/* sv/ibd_pkg.sv */
// Shared constants, types and helpers of the image box downsampler.
package ibd_pkg;

    localparam int IMAGE_SIZE = 512;
    localparam int COL_W      = $clog2(IMAGE_SIZE);
    localparam int IDX_W      = $clog2(COL_W);
    localparam int CNT_W      = 6;
    localparam int SCALE_W    = 7;
    localparam int MAX_SCALE  = 64;
    localparam int NUM_CH     = 3;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 20;
    localparam int DIV_W      = 13;
    localparam int D_W        = DIV_W + CH_W;
    localparam int STEP_W     = $clog2(CH_W + 1);
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SCALE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = CFG_IDX_W'(1);

    localparam logic [COL_W-1:0] LAST_POS = COL_W'(IMAGE_SIZE - 1);
    localparam logic [SUM_W-1:0] SUM_MAX  = '1;

    typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

    typedef struct packed {
        logic [COL_W-1:0] bx;
        logic             first;
        logic             last;
        logic             frame_end;
    } pos_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [CH_W-1:0]  b);
        logic [SUM_W:0] t;
        t = {1'b0, a} + {{(SUM_W + 1 - CH_W){1'b0}}, b};
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

endpackage

/* sv/ibd_line_store.sv */
// Per-column block accumulator memory, one synchronous read and one write port.
module ibd_line_store (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ibd_pkg::COL_W-1:0] wr_addr,
    input  ibd_pkg::sums_t            wr_data,
    input  logic                      rd_en,
    input  logic [ibd_pkg::COL_W-1:0] rd_addr,
    output ibd_pkg::sums_t            rd_data
);

    ibd_pkg::sums_t mem [ibd_pkg::IMAGE_SIZE];
    ibd_pkg::sums_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ibd_position.sv */
// Raster position counters and block column tracker with divide-on-rescale.
module ibd_position (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ibd_pkg::SCALE_W-1:0] scale,
    input  logic                        rescale,
    input  logic                        advance,
    output ibd_pkg::pos_t               pos,
    output logic                        busy
);

    logic [ibd_pkg::COL_W-1:0] col_reg, col_next;
    logic [ibd_pkg::COL_W-1:0] row_reg, row_next;
    logic [ibd_pkg::CNT_W-1:0] cib_reg, cib_next;
    logic [ibd_pkg::CNT_W-1:0] rib_reg, rib_next;
    logic [ibd_pkg::COL_W-1:0] bx_reg, bx_next;
    logic [ibd_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [ibd_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      busy_reg, busy_next;

    logic [ibd_pkg::CNT_W:0]   cib_inc, rib_inc, rem_inc, trial;
    logic                      last_col, last_row, trial_ge;

    assign cib_inc  = {1'b0, cib_reg} + 1'b1;
    assign rib_inc  = {1'b0, rib_reg} + 1'b1;
    assign rem_inc  = {1'b0, rem_reg} + 1'b1;
    assign trial    = {rem_reg, col_reg[idx_reg]};
    assign trial_ge = (trial >= scale);

    assign last_col = (cib_inc >= scale) || (col_reg == ibd_pkg::LAST_POS);
    assign last_row = (rib_inc >= scale) || (row_reg == ibd_pkg::LAST_POS);

    assign pos.bx        = bx_reg;
    assign pos.first     = (cib_reg == '0) && (rib_reg == '0);
    assign pos.last      = last_col && last_row;
    assign pos.frame_end = (col_reg == ibd_pkg::LAST_POS) && (row_reg == ibd_pkg::LAST_POS);
    assign busy          = busy_reg;

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        cib_next  = cib_reg;
        rib_next  = rib_reg;
        bx_next   = bx_reg;
        rem_next  = rem_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        priority if (rescale)
        begin
            busy_next = 1'b1;
            bx_next   = '0;
            rem_next  = '0;
            idx_next  = ibd_pkg::IDX_W'(ibd_pkg::COL_W - 1);
        end
        else if (busy_reg)
        begin
            bx_next  = {bx_reg[ibd_pkg::COL_W-2:0], trial_ge};
            rem_next = trial_ge ? ibd_pkg::CNT_W'(trial - scale) : trial[ibd_pkg::CNT_W-1:0];
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
        else if (advance)
        begin
            if (col_reg == ibd_pkg::LAST_POS)
            begin
                col_next = '0;
                cib_next = '0;
                bx_next  = '0;
                rem_next = '0;
                if (row_reg == ibd_pkg::LAST_POS)
                begin
                    row_next = '0;
                    rib_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    rib_next = (rib_inc >= scale) ? '0 : rib_inc[ibd_pkg::CNT_W-1:0];
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                cib_next = (cib_inc >= scale) ? '0 : cib_inc[ibd_pkg::CNT_W-1:0];
                if (rem_inc >= scale)
                begin
                    rem_next = '0;
                    bx_next  = bx_reg + 1'b1;
                end
                else
                begin
                    rem_next = rem_inc[ibd_pkg::CNT_W-1:0];
                end
            end
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            bx_reg   <= '0;
            rem_reg  <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cib_reg  <= cib_next;
            rib_reg  <= rib_next;
            bx_reg   <= bx_next;
            rem_reg  <= rem_next;
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

/* sv/ibd_divider.sv */
// Block sum divider with saturation and the output word register.
module ibd_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  ibd_pkg::sums_t            req_sum,
    input  logic [ibd_pkg::DIV_W-1:0] req_div,
    input  logic                      req_div_one,
    input  logic                      req_frame_end,
    output logic                      free,
    output logic                      out_tvalid,
    input  logic                      out_tready,
    output logic [23:0]               out_tdata,
    output logic                      out_tlast
);

    localparam logic [ibd_pkg::STEP_W-1:0] SAT_STEP = ibd_pkg::STEP_W'(ibd_pkg::CH_W);

    ibd_pkg::div_state_t             state_reg, state_next;
    ibd_pkg::sums_t                  rem_reg;
    ibd_pkg::pix_t                   q_reg;
    logic [ibd_pkg::NUM_CH-1:0]      sat_reg;
    logic [ibd_pkg::NUM_CH-1:0]      ge;
    logic [ibd_pkg::D_W-1:0]         d_reg;
    logic [ibd_pkg::STEP_W-1:0]      step_reg;
    logic                            fe_reg;
    ibd_pkg::pix_t                   out_pix;

    always_comb
    begin
        for (int c = 0; c < ibd_pkg::NUM_CH; c++)
        begin
            ge[c]      = ({1'b0, rem_reg[c]} >= d_reg);
            out_pix[c] = sat_reg[c] ? '1 : q_reg[c];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ibd_pkg::DIV_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = req_div_one ? ibd_pkg::DIV_DONE : ibd_pkg::DIV_RUN;
                end
            end
            ibd_pkg::DIV_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = ibd_pkg::DIV_DONE;
                end
            end
            ibd_pkg::DIV_DONE:
            begin
                if (out_tready)
                begin
                    state_next = ibd_pkg::DIV_IDLE;
                end
            end
            default:
            begin
                state_next = ibd_pkg::DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_tvalid = (state_reg == ibd_pkg::DIV_DONE);
        free       = (state_reg == ibd_pkg::DIV_IDLE) ||
                     ((state_reg == ibd_pkg::DIV_DONE) && out_tready);
    end

    assign out_tdata = out_pix;
    assign out_tlast = fe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ibd_pkg::DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ibd_pkg::DIV_IDLE) && req_valid)
        begin
            fe_reg   <= req_frame_end;
            d_reg    <= {req_div, {ibd_pkg::CH_W{1'b0}}};
            step_reg <= SAT_STEP;
            for (int c = 0; c < ibd_pkg::NUM_CH; c++)
            begin
                rem_reg[c] <= req_sum[c];
                q_reg[c]   <= req_sum[c][ibd_pkg::CH_W-1:0];
                sat_reg[c] <= (req_sum[c][ibd_pkg::SUM_W-1:ibd_pkg::CH_W] != '0);
            end
        end
        else if (state_reg == ibd_pkg::DIV_RUN)
        begin
            d_reg    <= d_reg >> 1;
            step_reg <= step_reg - 1'b1;
            for (int c = 0; c < ibd_pkg::NUM_CH; c++)
            begin
                if (step_reg == SAT_STEP)
                begin
                    sat_reg[c] <= ge[c];
                end
                else
                begin
                    if (ge[c])
                    begin
                        rem_reg[c] <= rem_reg[c] - d_reg[ibd_pkg::SUM_W-1:0];
                    end
                    q_reg[c] <= {q_reg[c][ibd_pkg::CH_W-2:0], ge[c]};
                end
            end
        end
    end

endmodule

/* sv/image_box_downsampler_unit.sv */
// Top level of the image box downsampler: configuration, accumulate stage, memory and divider.
//
// Pixels enter on the s_axis channel in raster order of a 512 x 512 image, one word per
// pixel, and downsampled pixels leave on m_axis in raster order of the blocks, with
// m_axis_tlast on the last output of each image. Registers are written on the cfg channel
// (index 0 block_scale, index 1 average_mode); the user must write them only while the
// block is idle, and the block itself does not enforce it. A pixel is read from the line
// store in the cycle it is accepted and written back in the next cycle; a bypass register
// covers consecutive pixels of the same block column, so pixels that complete no block
// can be accepted back to back. A block-completing pixel holds off another block-completing
// pixel in the next cycle. Its sums pass the accumulate register to the divider, which in
// subsample mode or at scale 1 goes straight to its output word, and in average mode loads,
// makes the saturation check and forms the eight quotient bits. The next block-completing
// pixel waits until the divider is free. A write of block_scale starts a division of the
// column position that realigns the block column; no pixel is taken meanwhile.
// Reset returns counters and registers to their defaults; the line store is not cleared.
// A stalled m_axis holds its word; pixels that complete no block are still taken.
module image_box_downsampler_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,   // blue, green, red
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,   // out_blue, out_green, out_red
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ibd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ibd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [ibd_pkg::SCALE_W-1:0]   block_scale_reg;
    logic                          average_mode_reg;
    logic [ibd_pkg::SCALE_W-1:0]   s_eff;
    logic [2*ibd_pkg::SCALE_W-1:0] ss_full;
    logic                          cfg_write, rescale;

    ibd_pkg::pos_t                 pos;
    logic                          pos_busy;
    logic                          advance;
    logic                          div_free;

    logic                          s1_valid_reg;
    ibd_pkg::pix_t                 s1_pix_reg;
    ibd_pkg::pos_t                 s1_pos_reg;
    logic                          byp_valid_reg;
    ibd_pkg::sums_t                byp_data_reg;

    ibd_pkg::sums_t                rd_data, old_sums, new_sums;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign rescale   = cfg_write && (cfg_index == ibd_pkg::REG_BLOCK_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_scale_reg  <= ibd_pkg::SCALE_W'(1);
            average_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ibd_pkg::REG_BLOCK_SCALE:
                begin
                    block_scale_reg <= cfg_data[ibd_pkg::SCALE_W-1:0];
                end
                ibd_pkg::REG_AVERAGE_MODE:
                begin
                    average_mode_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        priority if (block_scale_reg == '0)
        begin
            s_eff = ibd_pkg::SCALE_W'(1);
        end
        else if (block_scale_reg > ibd_pkg::SCALE_W'(ibd_pkg::MAX_SCALE))
        begin
            s_eff = ibd_pkg::SCALE_W'(ibd_pkg::MAX_SCALE);
        end
        else
        begin
            s_eff = block_scale_reg;
        end
    end

    assign ss_full = s_eff * s_eff;

    assign s_axis_tready = !pos_busy &&
                           (!pos.last || (div_free && !(s1_valid_reg && s1_pos_reg.last)));
    assign advance       = s_axis_tvalid && s_axis_tready;

    ibd_position u_position (
        .clk     (clk),
        .rst_n   (rst_n),
        .scale   (s_eff),
        .rescale (rescale),
        .advance (advance),
        .pos     (pos),
        .busy    (pos_busy)
    );

    always_comb
    begin
        old_sums = byp_valid_reg ? byp_data_reg : rd_data;
        for (int c = 0; c < ibd_pkg::NUM_CH; c++)
        begin
            if (s1_pos_reg.first)
            begin
                new_sums[c] = {{(ibd_pkg::SUM_W - ibd_pkg::CH_W){1'b0}}, s1_pix_reg[c]};
            end
            else if (average_mode_reg)
            begin
                new_sums[c] = ibd_pkg::sat_add(old_sums[c], s1_pix_reg[c]);
            end
            else
            begin
                new_sums[c] = old_sums[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= advance;
            byp_valid_reg <= s1_valid_reg && advance && (s1_pos_reg.bx == pos.bx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_pix_reg <= s_axis_tdata;
            s1_pos_reg <= pos;
        end
        byp_data_reg <= new_sums;
    end

    ibd_line_store u_line_store (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_pos_reg.bx),
        .wr_data (new_sums),
        .rd_en   (advance),
        .rd_addr (pos.bx),
        .rd_data (rd_data)
    );

    ibd_divider u_divider (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (s1_valid_reg && s1_pos_reg.last),
        .req_sum       (new_sums),
        .req_div       (ss_full[ibd_pkg::DIV_W-1:0]),
        .req_div_one   (!average_mode_reg || (s_eff == ibd_pkg::SCALE_W'(1))),
        .req_frame_end (s1_pos_reg.frame_end),
        .free          (div_free),
        .out_tvalid    (m_axis_tvalid),
        .out_tready    (m_axis_tready),
        .out_tdata     (m_axis_tdata),
        .out_tlast     (m_axis_tlast)
    );

endmodule

/* dv/image_box_downsampler_unit_tb.sv */
// Self-checking stream testbench for the image box downsampler with its own block-sum predictor.
module image_box_downsampler_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SUM_LIMIT    = (1 << ibd_pkg::SUM_W) - 1;
    localparam longint      CYCLE_LIMIT  = 40_000_000;
    localparam int          SETTLE       = 20;

    typedef struct packed {
        logic                     frame_end;
        logic [ibd_pkg::CH_W-1:0] red;
        logic [ibd_pkg::CH_W-1:0] green;
        logic [ibd_pkg::CH_W-1:0] blue;
    } down_pix_t;

    logic                           clk;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [23:0]                    s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [23:0]                    m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [ibd_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [ibd_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    ibd_pkg::pix_t pixel_q[$];
    down_pix_t     downsampled_q[$];
    int unsigned   pix_sent   = 0;
    int unsigned   pix_taken  = 0;
    int unsigned   mismatches = 0;
    longint        cycle_count = 0;
    logic          pix_fire = 1'b0;

    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned ready_left = 0;
    int unsigned stall_left = 0;

    int unsigned scale_reg    = 1;
    bit          avg_mode_reg = 1'b0;
    int unsigned col_pos      = 0;
    int unsigned row_pos      = 0;
    int unsigned col_blk      = 0;
    int unsigned row_blk      = 0;
    int unsigned channel_sums [ibd_pkg::IMAGE_SIZE][ibd_pkg::NUM_CH];

    image_box_downsampler_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void accumulate_pixel(input ibd_pkg::pix_t px);
        int unsigned   s;
        int unsigned   bx;
        int unsigned   div;
        int unsigned   q;
        int unsigned   t;
        bit            first;
        bit            last_col;
        bit            last_row;
        ibd_pkg::pix_t avg;
        down_pix_t     res;
        s = (scale_reg == 0) ? 1 : ((scale_reg > ibd_pkg::MAX_SCALE) ? ibd_pkg::MAX_SCALE
                                                                      : scale_reg);
        bx = col_pos / s;
        first = (row_blk == 0) && (col_blk == 0);
        for (int c = 0; c < ibd_pkg::NUM_CH; c++)
        begin
            if (first)
                channel_sums[bx][c] = px[c];
            else if (avg_mode_reg)
            begin
                t = channel_sums[bx][c] + px[c];
                channel_sums[bx][c] = (t > SUM_LIMIT) ? SUM_LIMIT : t;
            end
        end
        last_col = (col_blk + 1 >= s) || (col_pos == ibd_pkg::IMAGE_SIZE - 1);
        last_row = (row_blk + 1 >= s) || (row_pos == ibd_pkg::IMAGE_SIZE - 1);
        if (last_col && last_row)
        begin
            div = avg_mode_reg ? s * s : 1;
            for (int c = 0; c < ibd_pkg::NUM_CH; c++)
            begin
                q = channel_sums[bx][c] / div;
                avg[c] = (q > 255) ? 8'd255 : q[ibd_pkg::CH_W-1:0];
            end
            res.blue      = avg[0];
            res.green     = avg[1];
            res.red       = avg[2];
            res.frame_end = (row_pos == ibd_pkg::IMAGE_SIZE - 1) &&
                            (col_pos == ibd_pkg::IMAGE_SIZE - 1);
            downsampled_q.push_back(res);
        end
        if (col_pos >= ibd_pkg::IMAGE_SIZE - 1)
        begin
            col_pos = 0;
            col_blk = 0;
            if (row_pos >= ibd_pkg::IMAGE_SIZE - 1)
            begin
                row_pos = 0;
                row_blk = 0;
            end
            else
            begin
                row_pos++;
                row_blk = (row_blk + 1 >= s) ? 0 : row_blk + 1;
            end
        end
        else
        begin
            col_pos++;
            col_blk = (col_blk + 1 >= s) ? 0 : col_blk + 1;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : watch_ports
        down_pix_t got;
        down_pix_t want;
        pix_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tlast, m_axis_tdata};
                if (downsampled_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: expected no word, got %h", $time, got);
                end
                else
                begin
                    want = downsampled_q.pop_front();
                    check_field("out_blue", want.blue, got.blue);
                    check_field("out_green", want.green, got.green);
                    check_field("out_red", want.red, got.red);
                    check_field("frame_end", want.frame_end, got.frame_end);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ibd_pkg::REG_BLOCK_SCALE:  scale_reg = cfg_data[ibd_pkg::SCALE_W-1:0];
                    ibd_pkg::REG_AVERAGE_MODE: avg_mode_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                accumulate_pixel(s_axis_tdata);
                pix_taken++;
            end
        end
    end

    always @(negedge clk)
    begin : drive_pixels
        logic        next_valid;
        logic [23:0] next_data;
        next_valid = s_axis_tvalid && !pix_fire;
        next_data  = s_axis_tdata;
        if (rst_n && !next_valid)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pixel_q.size() > 0)
            begin
                next_data  = pixel_q.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= next_data;
    end

    always @(negedge clk)
    begin : pace_results
        if (ready_left > 0)
        begin
            ready_left--;
            m_axis_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            ready_left = $urandom_range(1, 40);
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("image_box_downsampler_unit_tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [ibd_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ibd_pkg::CFG_DATA_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input ibd_pkg::pix_t px);
        pixel_q.push_back(px);
        pix_sent++;
    endtask

    task automatic wait_idle();
        while (pix_taken != pix_sent || downsampled_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_phase(input bit set_scale, input int unsigned scale, input bit mode,
                             input int unsigned count);
        wait_idle();
        if (set_scale)
            write_reg(ibd_pkg::REG_BLOCK_SCALE, scale);
        write_reg(ibd_pkg::REG_AVERAGE_MODE, mode);
        for (int unsigned i = 0; i < count; i++)
            push_pixel(ibd_pkg::pix_t'($urandom()));
    endtask

    function automatic int unsigned pick_scale();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(ibd_pkg::MAX_SCALE + 1, 127);
            2:       return ibd_pkg::MAX_SCALE;
            3:       return $urandom_range(9, ibd_pkg::MAX_SCALE - 1);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    initial
    begin : sequencer
        int unsigned edge_scales[6] = '{0, 127, 65, 64, 2, 3};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_reg(ibd_pkg::REG_BLOCK_SCALE, 1);
        write_reg(ibd_pkg::REG_AVERAGE_MODE, 0);

        // fill the whole first row at scale 1 so every line store entry holds data
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'hAAAAAA);
        push_pixel(24'h555555);
        for (int i = 0; i < ibd_pkg::CH_W; i++)
            push_pixel({ibd_pkg::NUM_CH{ibd_pkg::CH_W'(1 << i)}});
        while (pix_sent < ibd_pkg::IMAGE_SIZE)
            push_pixel(ibd_pkg::pix_t'($urandom()));

        foreach (edge_scales[i])
            run_phase(1'b1, edge_scales[i], i[0], $urandom_range(20, 60));
        while (pix_sent < 1000)
            run_phase($urandom_range(0, 2) != 0, pick_scale(), $urandom_range(0, 1),
                      $urandom_range(1, 100));
        wait_idle();

        if (mismatches == 0 && downsampled_q.size() == 0)
            $display("image_box_downsampler_unit_tb passed");
        else
            $display("image_box_downsampler_unit_tb failed");
        $finish;
    end

endmodule
